/* rtl/scp_pkg.sv */
`default_nettype none

package scp_pkg;

    localparam int MAX_CARS    = 1024;
    localparam int CAR_W       = $clog2(MAX_CARS + 2);
    localparam int ADDR_W      = $clog2(MAX_CARS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CAR_COUNT      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STACK_CAPACITY = CFG_IDX_W'(1);

    typedef logic [CAR_W-1:0]  car_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        CMD_FAIL,
        CMD_PUSH,
        CMD_POP
    } cmd_kind_t;

    // push: car = first car of the run, count = cars left on the stack,
    //       addr = stack level before the run
    // pop:  car = wanted car, addr = top-of-stack entry
    typedef struct packed {
        cmd_kind_t kind;
        car_t      car;
        car_t      count;
        addr_t     addr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        car_t car_count;
        car_t stack_capacity;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUSH,
        BK_CHECK,
        BK_EMIT
    } bk_state_t;

endpackage

`default_nettype wire

/* rtl/scp_ifs.sv */
`default_nettype none

interface scp_in_if;
    import scp_pkg::*;

    logic valid;
    logic ready;
    car_t target_car;

    modport source (output valid, output target_car, input ready);
    modport sink (input valid, input target_car, output ready);
endinterface

interface scp_out_if;
    import scp_pkg::*;

    logic valid;
    logic ready;
    car_t push_count;
    logic pop_done;
    logic failed;

    modport source (output valid, output push_count, output pop_done, output failed,
                    input ready);
    modport sink (input valid, input push_count, input pop_done, input failed,
                  output ready);
endinterface

`default_nettype wire

/* rtl/stack_permutation_checker_core.sv */
`default_nettype none

// channel   dir  signals                                   transaction
// in_ch     in   valid, ready, target_car                  one wanted car
// out_ch    out  valid, ready, push_count, pop_done, failed one result per car
// cfg_*     in   cfg_we, cfg_index, cfg_data               one register write
//
// front classifies each car combinationally against next arrival and stack level
// back end per car: writes each car left on the stack through the store write port, then emits
// pop check steps: queue pop with store read, compare, result load
// reset clears state, stack store needs no clearing; entries are read only below level
// input stalls only when the 4-entry command queue is full; output stalls hold the back end

module stack_permutation_checker_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    scp_in_if.sink                             in_ch,
    scp_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [scp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scp_pkg::CAR_W-1:0]     cfg_data
);
    import scp_pkg::*;

    // configuration registers, to be written only while idle; the block itself does not enforce it
    cfg_t    cfg_reg, cfg_next;

    // command queue between classifier and stack engine
    logic    q_push;
    logic    q_pop;
    cmd_t    q_in;
    cmd_t    q_head;
    q_stat_t q_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAR_COUNT:      cfg_next.car_count      = cfg_data;
                REG_STACK_CAPACITY: cfg_next.stack_capacity = cfg_data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.car_count      <= CAR_W'(MAX_CARS);
            cfg_reg.stack_capacity <= CAR_W'(MAX_CARS);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: range, reachability and capacity checks, speculative pop
    scp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_data (q_in)
    );

    scp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // back: writes pushed runs into the store, checks pops, holds the result
    scp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (q_head),
        .q_pop  (q_pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

/* rtl/scp_front.sv */
`default_nettype none

module scp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    scp_in_if.sink               in_ch,
    input  wire scp_pkg::cfg_t   cfg,
    input  wire scp_pkg::q_stat_t q_stat,
    output logic                 q_push,
    output scp_pkg::cmd_t        q_data
);
    import scp_pkg::*;

    car_t next_arrival_reg, next_arrival_next;
    car_t stack_level_reg, stack_level_next;
    logic fail_reg, fail_next;

    car_t                 n_eff;
    car_t                 cap_eff;
    car_t                 t;
    car_t                 pushes;
    car_t                 run_len;
    car_t                 level_dec;
    logic [CAR_W:0]       level_sum;
    logic                 in_range;
    logic                 reach;
    logic                 fits;
    logic                 accept;

    always_comb
    begin
        n_eff   = (cfg.car_count > CAR_W'(MAX_CARS)) ? CAR_W'(MAX_CARS) : cfg.car_count;
        cap_eff = (cfg.stack_capacity > CAR_W'(MAX_CARS)) ? CAR_W'(MAX_CARS)
                                                          : cfg.stack_capacity;
        t         = in_ch.target_car;
        in_range  = (t != '0) && (t <= n_eff);
        reach     = (t >= next_arrival_reg);
        run_len   = t - next_arrival_reg;
        pushes    = run_len + CAR_W'(1);
        level_sum = {1'b0, stack_level_reg} + {1'b0, pushes};
        fits      = (level_sum <= {1'b0, cap_eff});
        level_dec = stack_level_reg - CAR_W'(1);
    end

    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign q_push      = accept;

    always_comb
    begin
        next_arrival_next = next_arrival_reg;
        stack_level_next  = stack_level_reg;
        fail_next         = fail_reg;
        q_data            = '{kind: CMD_FAIL, car: '0, count: '0, addr: '0};
        if (!fail_reg && in_range && reach && fits)
        begin
            q_data.kind       = CMD_PUSH;
            q_data.car        = next_arrival_reg;
            q_data.count      = run_len;
            q_data.addr       = stack_level_reg[ADDR_W-1:0];
            stack_level_next  = stack_level_reg + run_len;
            next_arrival_next = t + CAR_W'(1);
        end
        else if (!fail_reg && in_range && !reach && (stack_level_reg != '0))
        begin
            // assume the pop matches; the back end makes the failure sticky if not
            q_data.kind      = CMD_POP;
            q_data.car       = t;
            q_data.addr      = level_dec[ADDR_W-1:0];
            stack_level_next = level_dec;
        end
        else
        begin
            fail_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_arrival_reg <= CAR_W'(1);
            stack_level_reg  <= '0;
            fail_reg         <= 1'b0;
        end
        else if (accept)
        begin
            next_arrival_reg <= next_arrival_next;
            stack_level_reg  <= stack_level_next;
            fail_reg         <= fail_next;
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_level_reg <= CAR_W'(MAX_CARS))
        else $error("stack level above store depth");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg |=> fail_reg && $stable(stack_level_reg) && $stable(next_arrival_reg))
        else $error("front state changed after failure");

endmodule

`default_nettype wire

/* rtl/scp_queue.sv */
`default_nettype none

module scp_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire scp_pkg::cmd_t    push_data,
    input  wire logic             pop,
    output scp_pkg::cmd_t         head,
    output scp_pkg::q_stat_t      stat
);
    import scp_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/scp_back.sv */
`default_nettype none

module scp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scp_pkg::q_stat_t q_stat,
    input  wire scp_pkg::cmd_t    q_data,
    output logic                  q_pop,
    scp_out_if.source             out_ch
);
    import scp_pkg::*;

    car_t stack_mem [MAX_CARS];
    car_t rdata_reg;

    bk_state_t state_reg, state_next;
    car_t      target_reg, target_next;
    addr_t     wr_addr_reg, wr_addr_next;
    car_t      wr_car_reg, wr_car_next;
    car_t      left_reg, left_next;
    car_t      res_push_reg, res_push_next;
    logic      res_pop_reg, res_pop_next;
    logic      res_fail_reg, res_fail_next;
    logic      fail_seen_reg, fail_seen_next;
    logic      out_valid_reg, out_valid_next;
    car_t      out_push_reg, out_push_next;
    logic      out_pop_reg, out_pop_next;
    logic      out_fail_reg, out_fail_next;
    logic      mem_we;
    logic      slot_free;

    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        wr_addr_next   = wr_addr_reg;
        wr_car_next    = wr_car_reg;
        left_next      = left_reg;
        res_push_next  = res_push_reg;
        res_pop_next   = res_pop_reg;
        res_fail_next  = res_fail_reg;
        fail_seen_next = fail_seen_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_push_next  = out_push_reg;
        out_pop_next   = out_pop_reg;
        out_fail_next  = out_fail_reg;
        mem_we         = 1'b0;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop       = 1'b1;
                    target_next = q_data.car;
                    unique case (q_data.kind)
                        CMD_PUSH:
                        begin
                            res_push_next = q_data.count + CAR_W'(1);
                            res_pop_next  = 1'b1;
                            res_fail_next = 1'b0;
                            wr_addr_next  = q_data.addr;
                            wr_car_next   = q_data.car;
                            left_next     = q_data.count;
                            state_next    = (q_data.count != '0) ? BK_PUSH : BK_EMIT;
                        end
                        CMD_POP:
                        begin
                            // store read issued this cycle at q_data.addr
                            res_push_next = '0;
                            state_next    = BK_CHECK;
                        end
                        default:
                        begin
                            res_push_next = '0;
                            res_pop_next  = 1'b0;
                            res_fail_next = 1'b1;
                            state_next    = BK_EMIT;
                        end
                    endcase
                end
            end
            BK_PUSH:
            begin
                mem_we       = 1'b1;
                wr_addr_next = wr_addr_reg + ADDR_W'(1);
                wr_car_next  = wr_car_reg + CAR_W'(1);
                left_next    = left_reg - CAR_W'(1);
                if (left_reg == CAR_W'(1))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_CHECK:
            begin
                res_pop_next  = (rdata_reg == target_reg);
                res_fail_next = (rdata_reg != target_reg);
                state_next    = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (fail_seen_reg || res_fail_reg)
                    begin
                        out_push_next  = '0;
                        out_pop_next   = 1'b0;
                        out_fail_next  = 1'b1;
                        fail_seen_next = 1'b1;
                    end
                    else
                    begin
                        out_push_next = res_push_reg;
                        out_pop_next  = res_pop_reg;
                        out_fail_next = 1'b0;
                    end
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr_reg] <= wr_car_reg;
        end
        rdata_reg <= stack_mem[q_data.addr];
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        wr_addr_reg  <= wr_addr_next;
        wr_car_reg   <= wr_car_next;
        left_reg     <= left_next;
        res_push_reg <= res_push_next;
        res_pop_reg  <= res_pop_next;
        res_fail_reg <= res_fail_next;
        out_push_reg <= out_push_next;
        out_pop_reg  <= out_pop_next;
        out_fail_reg <= out_fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fail_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fail_seen_reg <= fail_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.push_count = out_push_reg;
    assign out_ch.pop_done   = out_pop_reg;
    assign out_ch.failed     = out_fail_reg;

    a_fail_forced: assert property (@(posedge clk) disable iff (!rst_n)
        fail_seen_reg && out_valid_reg |-> out_fail_reg)
        else $error("result after failure not marked failed");

    a_fail_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fail_reg |-> (out_push_reg == '0) && !out_pop_reg)
        else $error("failed result carries pushes or pop");

    a_push_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_PUSH |-> left_reg != '0)
        else $error("push run entered with nothing to write");

endmodule

`default_nettype wire
